### sv/sdtq_pkg.sv
// Package for the sorted deadline timer queue: sizes, codes and transfer types.
package sdtq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned MaxFire    = 16;
  localparam int unsigned IdxW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);
  localparam int unsigned FireW      = $clog2(MaxFire + 1);

  typedef enum logic {
    OP_TICK   = 1'b0,
    OP_INSERT = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_FIRED  = 2'd1,
    ST_REJECT = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [15:0] delay_seconds;
    logic [7:0]  tag;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  fired_tag;
    logic [15:0] fired_delay;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] deadline;
    logic [15:0] delay;
    logic [7:0]  tag;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic load_insert;
    logic tick;
    logic reject;
    logic ins_shift;
    logic ins_write;
    logic pop;
    logic none;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic ins_stop;
    logic due;
    logic next_due;
  } stat_t;

endpackage

### sv/sdtq_datapath.sv
// Datapath: time counter, sorted entry table, insert cursor and result register.
module sdtq_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sdtq_pkg::in_item_t item_i,
  input  sdtq_pkg::cmd_t    cmd_i,
  output sdtq_pkg::stat_t   stat_o,
  output logic              result_valid_o,
  output sdtq_pkg::result_t result_o
);

  sdtq_pkg::entry_t                 tbl_q [sdtq_pkg::QueueDepth];
  logic [31:0]                      time_q, time_d;
  logic [sdtq_pkg::CntW-1:0]        count_q, count_d;
  logic [sdtq_pkg::IdxW-1:0]        cursor_q;
  logic [sdtq_pkg::FireW-1:0]       fire_q;
  sdtq_pkg::entry_t                 new_q;
  logic                             valid_q;
  sdtq_pkg::result_t                res_q;

  logic [32:0]                      sum;
  logic [31:0]                      dead;
  logic [sdtq_pkg::IdxW-1:0]        prev_idx;
  logic [sdtq_pkg::FireW-1:0]       fire_nx;

  assign sum      = {1'b0, time_q} + {17'd0, item_i.delay_seconds};
  assign dead     = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign prev_idx = cursor_q - 1'b1;
  assign fire_nx  = fire_q + 1'b1;

  assign stat_o.full     = (count_q == sdtq_pkg::CntW'(sdtq_pkg::QueueDepth));
  assign stat_o.ins_stop = (cursor_q == '0) || (tbl_q[prev_idx].deadline <= new_q.deadline);
  assign stat_o.due      = (count_q != '0) && (tbl_q[0].deadline <= time_q)
                           && (fire_q < sdtq_pkg::FireW'(sdtq_pkg::MaxFire));
  assign stat_o.next_due = (count_q > sdtq_pkg::CntW'(1)) && (tbl_q[1].deadline <= time_q)
                           && (fire_nx < sdtq_pkg::FireW'(sdtq_pkg::MaxFire));

  always_comb begin
    time_d  = time_q;
    count_d = count_q;
    if (cmd_i.tick && (time_q != 32'hFFFF_FFFF)) begin
      time_d = time_q + 32'd1;
    end
    if (cmd_i.ins_write) begin
      count_d = count_q + 1'b1;
    end else if (cmd_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      time_q  <= time_d;
      count_q <= count_d;
      valid_q <= cmd_i.reject | cmd_i.none | cmd_i.pop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_insert) begin
      new_q.deadline <= dead;
      new_q.delay    <= item_i.delay_seconds;
      new_q.tag      <= item_i.tag;
      cursor_q       <= count_q[sdtq_pkg::IdxW-1:0];
    end else if (cmd_i.ins_shift) begin
      cursor_q <= prev_idx;
    end
    if (cmd_i.load_insert || cmd_i.tick) begin
      fire_q <= '0;
    end else if (cmd_i.pop) begin
      fire_q <= fire_nx;
    end
    if (cmd_i.ins_shift) begin
      tbl_q[cursor_q] <= tbl_q[prev_idx];
    end else if (cmd_i.ins_write) begin
      tbl_q[cursor_q] <= new_q;
    end else if (cmd_i.pop) begin
      for (int i = 0; i < sdtq_pkg::QueueDepth - 1; i++) begin
        tbl_q[i] <= tbl_q[i+1];
      end
    end
    if (cmd_i.pop) begin
      res_q.status      <= sdtq_pkg::ST_FIRED;
      res_q.fired_tag   <= tbl_q[0].tag;
      res_q.fired_delay <= tbl_q[0].delay;
      res_q.last        <= ~stat_o.next_due;
    end else begin
      res_q.status      <= cmd_i.reject ? sdtq_pkg::ST_REJECT : sdtq_pkg::ST_NONE;
      res_q.fired_tag   <= '0;
      res_q.fired_delay <= '0;
      res_q.last        <= 1'b1;
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

### sv/sdtq_ctrl.sv
// Controller: accepts items, sequences the insert walk and the drain of due alarms.
module sdtq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sdtq_pkg::opcode_e opcode_i,
  input  sdtq_pkg::stat_t  stat_i,
  output sdtq_pkg::cmd_t   cmd_o,
  output logic             busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (opcode_i == sdtq_pkg::OP_INSERT) begin
            if (stat_i.full) begin
              cmd_o.reject = 1'b1;
            end else begin
              cmd_o.load_insert = 1'b1;
              state_d           = S_INSERT;
            end
          end else begin
            cmd_o.tick = 1'b1;
            state_d    = S_DRAIN;
          end
        end
      end
      S_INSERT: begin
        if (stat_i.ins_stop) begin
          cmd_o.ins_write = 1'b1;
          state_d         = S_DRAIN;
        end else begin
          cmd_o.ins_shift = 1'b1;
        end
      end
      S_DRAIN: begin
        if (stat_i.due) begin
          cmd_o.pop = 1'b1;
          if (!stat_i.next_due) begin
            state_d = S_IDLE;
          end
        end else begin
          cmd_o.none = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
    end
  end

  assign busy_o = busy_q;

endmodule

### sv/sorted_deadline_timer_queue.sv
// Sorted deadline timer queue: saturating time counter and a deadline-ordered alarm table.
//
// Input: an item transfers on a rising edge with start_i high and busy_o low.
//   item_i.opcode selects a tick (time + 1, saturating) or an insert of an alarm
//   with deadline = time + delay_seconds (saturating), placed after equal deadlines.
// Output: each result is on result_o for one cycle with result_valid_o high;
//   the receiver cannot stall. Every due alarm fires in deadline order, the final
//   result of an item carries last. With nothing due, one status result is given;
//   an insert into a full table gives one reject result.
// Timing: a tick goes straight to the drain state; an insert first walks the table,
//   moving one entry per cycle past each entry with a later deadline, then writes
//   the new entry and goes to the drain state. There each fired alarm or the status
//   result is registered onto result_o; further fired alarms follow one per cycle.
//   A reject appears in the cycle after the transfer. busy_o drops in the cycle the
//   last result is shown, so the next item may transfer then.
// Reset: time and entry count clear to zero; table contents need no clearing.
module sorted_deadline_timer_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sdtq_pkg::in_item_t item_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output sdtq_pkg::result_t result_o
);

  sdtq_pkg::cmd_t  cmd;
  sdtq_pkg::stat_t stat;

  sdtq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (item_i.opcode),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  sdtq_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### sv/sdtq_checker.sv
// Port-level checks for the sorted deadline timer queue, bound to the top level.
module sdtq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start_i,
  input sdtq_pkg::in_item_t item_i,
  input logic              busy_o,
  input logic              result_valid_o,
  input sdtq_pkg::result_t result_o
);

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == sdtq_pkg::ST_NONE)
    |-> result_o.last && (result_o.fired_tag == '0) && (result_o.fired_delay == '0))
    else $error("nothing-fired result malformed");

  a_reject_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == sdtq_pkg::ST_REJECT)
    |-> result_o.last && (result_o.fired_tag == '0) && (result_o.fired_delay == '0))
    else $error("reject result malformed");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last
    |=> result_valid_o && (result_o.status == sdtq_pkg::ST_FIRED))
    else $error("fired burst broken before last");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (item_i.opcode == sdtq_pkg::OP_TICK) |=> busy_o)
    else $error("tick transfer did not start work");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .item_i         (item_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

### verif/tb.sv
// Testbench for sorted_deadline_timer_queue: directed and random ticks and inserts, scoreboard check.
module tb;
  import sdtq_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 258;
  localparam int unsigned DrainCycles = 40;

  class alarm_table_sb;
    logic [31:0] time_now;
    int unsigned count;
    logic [31:0] deadline[QueueDepth];
    logic [15:0] delay[QueueDepth];
    logic [7:0]  tag[QueueDepth];
    result_t     firing_q[$];
    int unsigned mismatches;

    function new();
      time_now   = '0;
      count      = 0;
      mismatches = 0;
    endfunction

    function void push_result(status_e st, logic [7:0] t, logic [15:0] d, logic lst);
      result_t r;
      r.status      = st;
      r.fired_tag   = t;
      r.fired_delay = d;
      r.last        = lst;
      firing_q.push_back(r);
    endfunction

    // Expected transfers caused by one accepted item.
    function void predict_firing(in_item_t it);
      logic [32:0] sum;
      logic [31:0] due_at;
      int unsigned pos;
      int unsigned n;
      result_t     r;
      if (it.opcode == OP_INSERT) begin
        if (count >= QueueDepth) begin
          push_result(ST_REJECT, 8'h00, 16'h0000, 1'b1);
          return;
        end
        sum    = {1'b0, time_now} + {17'b0, it.delay_seconds};
        due_at = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        pos    = 0;
        while (pos < count && deadline[pos] <= due_at) pos++;
        for (int i = count; i > pos; i--) begin
          deadline[i] = deadline[i-1];
          delay[i]    = delay[i-1];
          tag[i]      = tag[i-1];
        end
        deadline[pos] = due_at;
        delay[pos]    = it.delay_seconds;
        tag[pos]      = it.tag;
        count++;
      end else if (time_now != 32'hFFFF_FFFF) begin
        time_now++;
      end
      n = 0;
      while (n < MaxFire && count > 0 && deadline[0] <= time_now) begin
        push_result(ST_FIRED, tag[0], delay[0], 1'b0);
        for (int i = 1; i < count; i++) begin
          deadline[i-1] = deadline[i];
          delay[i-1]    = delay[i];
          tag[i-1]      = tag[i];
        end
        count--;
        n++;
      end
      if (n == 0) begin
        push_result(ST_NONE, 8'h00, 16'h0000, 1'b1);
      end else begin
        r      = firing_q.pop_back();
        r.last = 1'b1;
        firing_q.push_back(r);
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (firing_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result status=%0d tag=%h delay=%h last=%b",
                                got.status, got.fired_tag, got.fired_delay, got.last));
        return;
      end
      want = firing_q.pop_front();
      if (got.status !== want.status || got.fired_tag !== want.fired_tag ||
          got.fired_delay !== want.fired_delay || got.last !== want.last) begin
        note_mismatch($sformatf(
          "mismatch exp status=%0d tag=%h delay=%h last=%b got status=%0d tag=%h delay=%h last=%b",
          want.status, want.fired_tag, want.fired_delay, want.last,
          got.status, got.fired_tag, got.fired_delay, got.last));
      end
    endfunction

    function int unsigned pending();
      return firing_q.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start_i;
  in_item_t      item_i;
  logic          busy_o;
  logic          result_valid_o;
  result_t       result_o;
  alarm_table_sb sb;
  int unsigned   cycles = 0;

  sorted_deadline_timer_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .item_i         (item_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) sb.check_result(result_o);
  end

  function automatic in_item_t make_item(opcode_e op, logic [15:0] d, logic [7:0] t);
    in_item_t it;
    it.opcode        = op;
    it.delay_seconds = d;
    it.tag           = t;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input in_item_t it);
    start_i <= 1'b1;
    item_i  <= it;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    sb.predict_firing(it);
    @(negedge clk_i);
  endtask

  task automatic sender_gap(input bit quiet);
    while (!quiet && $urandom_range(99) < 24) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  initial begin
    int unsigned n;
    int unsigned sel;
    bit          quiet;
    logic [15:0] d;
    sb      = new();
    rst_ni  = 1'b0;
    start_i = 1'b0;
    item_i  = make_item(OP_TICK, 16'h0000, 8'h00);
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: tick with nothing due, immediate fire, far deadline, fill, reject, drain.
    send_item(make_item(OP_TICK, 16'hFFFF, 8'hFF));
    sender_gap(1'b0);
    send_item(make_item(OP_INSERT, 16'h0000, 8'hFF));
    sender_gap(1'b0);
    send_item(make_item(OP_INSERT, 16'hFFFF, 8'h00));
    for (int i = 0; i < QueueDepth - 1; i++) begin
      sender_gap(1'b0);
      send_item(make_item(OP_INSERT, 16'(1 + (i % 3)), 8'(8'hA0 ^ i)));
    end
    sender_gap(1'b0);
    send_item(make_item(OP_INSERT, 16'h0005, 8'h55));
    repeat (3) begin
      sender_gap(1'b0);
      send_item(make_item(OP_TICK, 16'($urandom), 8'($urandom)));
    end

    n = 0;
    while (n < RandomItems) begin
      quiet = (n >= 100 && n < 170);
      if ($urandom_range(24) == 0) begin
        // Burst of short inserts that runs the table full.
        repeat (QueueDepth + 2) begin
          sender_gap(quiet);
          send_item(make_item(OP_INSERT, 16'($urandom_range(1, 6)), 8'($urandom)));
          n++;
        end
      end else begin
        sender_gap(quiet);
        if ($urandom_range(99) < 45) begin
          send_item(make_item(OP_TICK, 16'($urandom), 8'($urandom)));
        end else begin
          sel = $urandom_range(99);
          if (sel < 70)
            d = 16'($urandom_range(6));
          else if (sel < 95 || sb.count >= 8)
            d = 16'($urandom_range(7, 40));
          else
            d = 16'($urandom);
          send_item(make_item(OP_INSERT, d, 8'($urandom)));
        end
        n++;
      end
    end
    start_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
